// ----- rtl/delayed_token_bucket_shaper_unit_defines.svh -----
// Assertion macros used by the shaper top level.
`ifndef DELAYED_TOKEN_BUCKET_SHAPER_UNIT_DEFINES_SVH
`define DELAYED_TOKEN_BUCKET_SHAPER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define DTBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define DTBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/dtbs_pkg.sv -----
// Types, codes and constants of the delayed token bucket shaper.
`timescale 1ns / 1ps
package dtbs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 10;

  localparam logic [23:0] TOKEN_MAX     = 24'hFFFFFF;
  localparam logic [15:0] RATE_RESET    = 16'd512;
  localparam logic [15:0] LATENCY_RESET = 16'd100;

  // Event selector codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ARRIVE = 2'd1;
  localparam logic [1:0] FUNC_SEND   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_SENT     = 3'd2;
  localparam logic [2:0] ST_NOTHING  = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_RATE    = 2'd0;
  localparam logic [1:0] REG_LATENCY = 2'd1;

  // One queued chunk
  typedef struct packed {
    logic [15:0] size;
    logic [9:0]  handle;
    logic [31:0] due;
  } entry_t;

  // Per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  sent_handle;
    logic [15:0] sent_size;
    logic [3:0]  queued_count;
    logic        closed;
  } res_t;

endpackage

// ----- rtl/dtbs_cell.sv -----
// One queue cell: holds a chunk and takes its upper neighbor's chunk on a shift.
`timescale 1ns / 1ps
module dtbs_cell (
  input  logic                clk_i,
  input  dtbs_pkg::cell_ctrl_t ctrl_i,
  input  dtbs_pkg::entry_t    load_data_i,
  input  dtbs_pkg::entry_t    next_data_i,
  output dtbs_pkg::entry_t    data_o
);

  dtbs_pkg::entry_t data_q;
  dtbs_pkg::entry_t data_d;

  // Pick the new content: fresh chunk, neighbor's chunk, or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/dtbs_out_buf.sv -----
// Result output register with a one-entry skid stage.
`timescale 1ns / 1ps
module dtbs_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dtbs_pkg::res_t res_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dtbs_pkg::res_t res_o
);

  logic           out_valid_q;
  logic           skid_valid_q;
  dtbs_pkg::res_t out_q;
  dtbs_pkg::res_t skid_q;
  logic           out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign space_o  = !skid_valid_q;

  // Track which stages hold a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Move payloads: skid drains into the output stage first
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= res_i;
        end
      end else if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- rtl/delayed_token_bucket_shaper_unit.sv -----
// Top level of the delayed token bucket shaper: control, token bucket, cell chain.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | func, now_ms, chunk_size, chunk_handle
//   out     | output    | out_valid_o / out_ready_i | status, sent_handle, sent_size, ...
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_ready_o is high; its result is registered in the output buffer.
// The queue is a chain of cells with cell 0 as head; a send shifts every cell down one.
// A one-entry skid stage lets one more item in while a result waits; in_ready_o drops
// only when both output stages are full. Configuration writes are taken every cycle.
// Reset clears counters, flags and the bucket (to 512); cell contents are not reset.
`timescale 1ns / 1ps
`include "delayed_token_bucket_shaper_unit_defines.svh"
module delayed_token_bucket_shaper_unit #(
  parameter int unsigned QUEUE_DEPTH = dtbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] chunk_size_i,
  input  logic [9:0]  chunk_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  sent_handle_o,
  output logic [15:0] sent_size_o,
  output logic [3:0]  queued_count_o,
  output logic        closed_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]       rate_q;
  logic [15:0]       latency_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              head_ready_q, head_ready_d;
  logic [23:0]       token_q, token_d;
  logic              end_seen_q, end_seen_d;

  logic              in_acc;
  logic              buf_space;
  logic              enq;
  logic              deq;
  logic              has_room;
  logic              past_due;
  logic [31:0]       due_diff;
  logic [24:0]       tok_sum;
  dtbs_pkg::entry_t  head;
  dtbs_pkg::entry_t  new_entry;
  dtbs_pkg::res_t    res;
  dtbs_pkg::res_t    res_out;

  dtbs_pkg::entry_t     cell_data [QUEUE_DEPTH];
  dtbs_pkg::cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

  assign in_ready_o  = buf_space;
  assign in_acc      = in_valid_i && buf_space;
  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= dtbs_pkg::RATE_RESET;
      latency_q <= dtbs_pkg::LATENCY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dtbs_pkg::REG_RATE:    rate_q    <= cfg_data_i;
        dtbs_pkg::REG_LATENCY: latency_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign head      = cell_data[0];
  assign due_diff  = now_ms_i - head.due;
  assign past_due  = (due_diff != 32'd0) && !due_diff[31];
  assign tok_sum   = {1'b0, token_q} + {9'd0, rate_q};
  assign has_room  = fill_q < FILL_W'(QUEUE_DEPTH);

  assign new_entry.size   = chunk_size_i;
  assign new_entry.handle = chunk_handle_i;
  assign new_entry.due    = now_ms_i + {16'd0, latency_q};

  // Decode the event and form next state and result
  always_comb begin
    fill_d       = fill_q;
    head_ready_d = head_ready_q;
    token_d      = token_q;
    end_seen_d   = end_seen_q;
    enq          = 1'b0;
    deq          = 1'b0;
    res.status      = dtbs_pkg::ST_DONE;
    res.sent_handle = 10'd0;
    res.sent_size   = 16'd0;
    case (func_i)
      dtbs_pkg::FUNC_TICK: begin
        if (fill_q != '0 && past_due) begin
          head_ready_d = 1'b1;
          token_d = tok_sum[24] ? dtbs_pkg::TOKEN_MAX : tok_sum[23:0];
        end else begin
          token_d = {8'd0, rate_q};
        end
      end
      dtbs_pkg::FUNC_ARRIVE: begin
        if (!has_room) begin
          res.status = dtbs_pkg::ST_REJECTED;
        end else if (chunk_size_i == 16'd0) begin
          end_seen_d = 1'b1;
        end else begin
          enq        = 1'b1;
          fill_d     = fill_q + FILL_W'(1);
          res.status = dtbs_pkg::ST_QUEUED;
        end
      end
      dtbs_pkg::FUNC_SEND: begin
        if (fill_q != '0 && head_ready_q && token_q >= {8'd0, head.size}) begin
          deq             = 1'b1;
          fill_d          = fill_q - FILL_W'(1);
          head_ready_d    = 1'b0;
          token_d         = token_q - {8'd0, head.size};
          res.status      = dtbs_pkg::ST_SENT;
          res.sent_handle = head.handle;
          res.sent_size   = head.size;
        end else begin
          res.status = dtbs_pkg::ST_NOTHING;
        end
      end
      default: ;
    endcase
    res.queued_count = 4'(fill_d);
    res.closed       = end_seen_d && (fill_d == '0);
  end

  // Update control state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      head_ready_q <= 1'b0;
      token_q      <= {8'd0, dtbs_pkg::RATE_RESET};
      end_seen_q   <= 1'b0;
    end else if (in_acc) begin
      fill_q       <= fill_d;
      head_ready_q <= head_ready_d;
      token_q      <= token_d;
      end_seen_q   <= end_seen_d;
    end
  end

  // Build the cell chain; a new chunk lands in the first free cell
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].load  = in_acc && enq && (fill_q == FILL_W'(i));
    assign cell_ctrl[i].shift = in_acc && deq;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      dtbs_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .load_data_i (new_entry),
        .next_data_i (cell_data[i]),
        .data_o      (cell_data[i])
      );
    end else begin : g_mid
      dtbs_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (cell_ctrl[i]),
        .load_data_i (new_entry),
        .next_data_i (cell_data[i+1]),
        .data_o      (cell_data[i])
      );
    end
  end

  dtbs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .res_i       (res),
    .space_o     (buf_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign status_o       = res_out.status;
  assign sent_handle_o  = res_out.sent_handle;
  assign sent_size_o    = res_out.sent_size;
  assign queued_count_o = res_out.queued_count;
  assign closed_o       = res_out.closed;

  // Queue never overfills
  `DTBS_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_W'(QUEUE_DEPTH), "fill exceeds depth")
  // A ready head implies a queued chunk
  `DTBS_ASSERT(a_ready_nonempty, clk_i, rst_ni, head_ready_q |-> fill_q != '0, "ready on empty")
  // A send removes exactly one chunk and clears the ready flag
  `DTBS_ASSERT(a_send_pops, clk_i, rst_ni, (in_acc && deq) |=> (fill_q == $past(fill_q) - FILL_W'(1)) && !head_ready_q, "send did not pop")

endmodule
